FILE: hdl/rit_pkg.sv
// Shared types, constants and alphabet lookup for the radix integer-to-text block.
package rit_pkg;

  // Alphabet limits and character codes
  localparam int unsigned MAX_DIGITS  = 16;
  localparam int unsigned DIGIT_SLOTS = 32;
  localparam logic [7:0]  CH_PLUS     = 8'h2B;
  localparam logic [7:0]  CH_MINUS    = 8'h2D;
  localparam logic [7:0]  CH_SPACE    = 8'h20;
  localparam logic [7:0]  CH_ZED      = 8'h7A;

  // Configuration register indexes
  localparam logic [1:0] REG_BASE_LENGTH = 2'd0;
  localparam logic [1:0] REG_DIGITS_LOW  = 2'd1;
  localparam logic [1:0] REG_DIGITS_HIGH = 2'd2;

  // Reset values of the configuration registers
  localparam logic [4:0]  BASE_LENGTH_RST = 5'd10;
  localparam logic [63:0] DIGITS_LOW_RST  = 64'd3978425819141910832;
  localparam logic [63:0] DIGITS_HIGH_RST = 64'd14648;

  // One queued number: sign and unsigned magnitude
  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
  } rit_item_t;

  // Back-end handshake status toward the top level
  typedef struct packed {
    logic pop;
    logic idle;
  } rit_back_stat_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_DIV,
    BK_SIGN,
    BK_EMIT_RD,
    BK_EMIT_OUT
  } rit_back_state_t;

  // Pick alphabet character idx out of the two packed words
  function automatic logic [7:0] alpha_char(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic [3:0] idx);
    logic [63:0] word;
    word = idx[3] ? hi : lo;
    return word[{idx[2:0], 3'b000} +: 8];
  endfunction

endpackage

FILE: hdl/rit_front.sv
// Front end: checks the alphabet, takes the sign and magnitude of each accepted transaction.
module rit_front (
  input  logic                start,
  input  logic                busy,
  input  logic signed [31:0]  in_value,
  input  logic [4:0]          base_length,
  input  logic [63:0]         digits_low,
  input  logic [63:0]         digits_high,
  output logic                push,
  output rit_pkg::rit_item_t  item
);

  logic alpha_ok;

  // Validate the alphabet: length, forbidden and out-of-range characters, duplicates
  always_comb begin
    logic [7:0] ci;
    alpha_ok = (base_length >= 5'd2) && (base_length <= 5'(rit_pkg::MAX_DIGITS));
    for (int i = 0; i < 16; i++) begin
      ci = rit_pkg::alpha_char(digits_low, digits_high, 4'(i));
      if (5'(i) < base_length) begin
        if (ci == rit_pkg::CH_PLUS || ci == rit_pkg::CH_MINUS ||
            ci < rit_pkg::CH_SPACE || ci > rit_pkg::CH_ZED) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < 16; j++) begin
          if (5'(j) < base_length &&
              rit_pkg::alpha_char(digits_low, digits_high, 4'(j)) == ci) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // Queue the number only with a usable alphabet; drop it otherwise
  assign push     = start && !busy && alpha_ok;
  assign item.neg = in_value[31];
  assign item.mag = in_value[31] ? (32'd0 - 32'(in_value)) : 32'(in_value);

endmodule

FILE: hdl/rit_queue.sv
// Two-entry queue between the front end and the back end.
module rit_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rit_pkg::rit_item_t push_item,
  input  logic               pop,
  output rit_pkg::rit_item_t pop_item,
  output logic               empty,
  output logic               full
);

  rit_pkg::rit_item_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign empty    = (count_r == 2'd0);
  assign full     = (count_r == 2'd2);
  assign pop_item = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hdl/rit_back.sv
// Back end: divides the magnitude down digit by digit and emits the characters.
module rit_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [4:0]             base_length,
  input  logic [63:0]            digits_low,
  input  logic [63:0]            digits_high,
  input  logic                   q_empty,
  input  rit_pkg::rit_item_t     q_item,
  output rit_pkg::rit_back_stat_t stat,
  output logic                   out_strobe,
  output logic [7:0]             out_character,
  output logic                   out_last
);

  rit_pkg::rit_back_state_t state_r, state_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [1:0]  beat_r, beat_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        neg_r, neg_nxt;
  logic [3:0]  mem [rit_pkg::DIGIT_SLOTS];
  logic [3:0]  rdata_r;
  logic        we;
  logic [3:0]  wdata;
  logic [7:0]  qbits;
  logic [3:0]  rem_step;

  // Long division of the top byte of the magnitude, one bit per step
  always_comb begin
    logic [4:0] part;
    rem_step = rem_r;
    qbits    = 8'd0;
    for (int b = 7; b >= 0; b--) begin
      part = {rem_step, mag_r[24 + b]};
      if (part >= base_length) begin
        part     = part - base_length;
        qbits[b] = 1'b1;
      end
      rem_step = part[3:0];
    end
  end

  // Sequence division, sign and digit emission
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    beat_nxt      = beat_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    we            = 1'b0;
    wdata         = rem_r;
    stat.pop      = 1'b0;
    stat.idle     = 1'b0;
    out_strobe    = 1'b0;
    out_character = rit_pkg::alpha_char(digits_low, digits_high, rdata_r);
    out_last      = (idx_r == 5'd0);
    unique case (state_r)
      rit_pkg::BK_IDLE: begin
        stat.idle = 1'b1;
        if (!q_empty) begin
          stat.pop  = 1'b1;
          mag_nxt   = q_item.mag;
          neg_nxt   = q_item.neg;
          cnt_nxt   = 5'd0;
          state_nxt = rit_pkg::BK_CHECK;
        end
      end
      rit_pkg::BK_CHECK: begin
        if (mag_r >= {27'd0, base_length} && cnt_r != 5'(rit_pkg::DIGIT_SLOTS - 1)) begin
          rem_nxt   = 4'd0;
          beat_nxt  = 2'd0;
          state_nxt = rit_pkg::BK_DIV;
        end else begin
          // Final digit: store it and start from the top
          we        = 1'b1;
          wdata     = mag_r[3:0];
          idx_nxt   = cnt_r;
          state_nxt = neg_r ? rit_pkg::BK_SIGN : rit_pkg::BK_EMIT_RD;
        end
      end
      rit_pkg::BK_DIV: begin
        mag_nxt  = {mag_r[23:0], qbits};
        rem_nxt  = rem_step;
        beat_nxt = beat_r + 2'd1;
        if (beat_r == 2'd3) begin
          we        = 1'b1;
          wdata     = rem_step;
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = rit_pkg::BK_CHECK;
        end
      end
      rit_pkg::BK_SIGN: begin
        out_strobe    = 1'b1;
        out_character = rit_pkg::CH_MINUS;
        out_last      = 1'b0;
        state_nxt     = rit_pkg::BK_EMIT_RD;
      end
      rit_pkg::BK_EMIT_RD: begin
        state_nxt = rit_pkg::BK_EMIT_OUT;
      end
      rit_pkg::BK_EMIT_OUT: begin
        out_strobe = 1'b1;
        if (idx_r == 5'd0) begin
          state_nxt = rit_pkg::BK_IDLE;
        end else begin
          idx_nxt   = idx_r - 5'd1;
          state_nxt = rit_pkg::BK_EMIT_RD;
        end
      end
      default: begin
        state_nxt = rit_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rit_pkg::BK_IDLE;
      beat_r  <= 2'd0;
      cnt_r   <= 5'd0;
      idx_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      beat_r  <= beat_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Hold the payload of the number in work
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  // Digit store: write at the digit count, registered read at the emit index
  always_ff @(posedge clk) begin
    if (we) begin
      mem[cnt_r] <= wdata;
    end
    rdata_r <= mem[idx_r];
  end

endmodule

FILE: hdl/radix_integer_to_text.sv
// Top level of the radix integer-to-text block: configuration registers, front, queue, back.
// A number is accepted when start is high and busy is low; busy rises only while the
// two-entry queue is full. Each number comes out as an optional '-' and then its digits,
// most significant first, one character per out_strobe cycle, with out_last on the final
// digit; the receiver cannot stall and must take every strobed character. In the back end,
// each radix division handles a byte of the magnitude per BK_DIV beat in restoring bit
// steps, then a check state; a sign has its own output state; each digit is a registered
// read of the digit store and an output cycle. Numbers written while the alphabet is
// invalid are dropped without output. The user must write configuration (APB, 64-bit
// data, registers at byte addresses 0, 8 and 16) only while idle; the block does not check.
module radix_integer_to_text (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_value,
  output logic               out_strobe,
  output logic [7:0]         out_character,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic [4:0]  base_length_r;
  logic [63:0] digits_low_r;
  logic [63:0] digits_high_r;
  logic        cfg_write;
  logic [1:0]  cfg_sel;

  logic                    push;
  rit_pkg::rit_item_t      push_item;
  rit_pkg::rit_item_t      pop_item;
  logic                    q_empty;
  logic                    q_full;
  rit_pkg::rit_back_stat_t back_stat;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_sel   = paddr[4:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_length_r <= rit_pkg::BASE_LENGTH_RST;
      digits_low_r  <= rit_pkg::DIGITS_LOW_RST;
      digits_high_r <= rit_pkg::DIGITS_HIGH_RST;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        rit_pkg::REG_BASE_LENGTH: base_length_r <= pwdata[4:0];
        rit_pkg::REG_DIGITS_LOW:  digits_low_r  <= pwdata;
        rit_pkg::REG_DIGITS_HIGH: digits_high_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (cfg_sel)
      rit_pkg::REG_BASE_LENGTH: prdata = {59'd0, base_length_r};
      rit_pkg::REG_DIGITS_LOW:  prdata = digits_low_r;
      rit_pkg::REG_DIGITS_HIGH: prdata = digits_high_r;
      default:                  prdata = 64'd0;
    endcase
  end

  assign busy = q_full;

  rit_front u_front (
    .start       (start),
    .busy        (q_full),
    .in_value    (in_value),
    .base_length (base_length_r),
    .digits_low  (digits_low_r),
    .digits_high (digits_high_r),
    .push        (push),
    .item        (push_item)
  );

  rit_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (back_stat.pop),
    .pop_item  (pop_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  rit_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .base_length   (base_length_r),
    .digits_low    (digits_low_r),
    .digits_high   (digits_high_r),
    .q_empty       (q_empty),
    .q_item        (pop_item),
    .stat          (back_stat),
    .out_strobe    (out_strobe),
    .out_character (out_character),
    .out_last      (out_last)
  );

  // Never push into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
    else $error("push into full queue");

  // Pop only from a filled queue, and only when the back end is idle
  assert property (@(posedge clk) disable iff (!rst_n)
                   back_stat.pop |-> (!q_empty && back_stat.idle))
    else $error("pop without entry or while busy");

  // A character strobe is never directly followed by another
  assert property (@(posedge clk) disable iff (!rst_n) out_strobe |=> !out_strobe)
    else $error("back-to-back character strobes");

  // The back end is idle right after the last character
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_strobe && out_last) |=> back_stat.idle)
    else $error("back end not idle after last character");

endmodule
